FILE: design/aars_pkg.sv
package aars_pkg;

	// command codes of an input item
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// kind codes of a result item
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_READING = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_SETTLE_LIMIT   = 2'd2;

	// configuration reset values
	localparam logic [11:0] LOW_THRESHOLD_RESET  = 12'd1750;
	localparam logic [11:0] HIGH_THRESHOLD_RESET = 12'd3900;
	localparam logic [3:0]  SETTLE_LIMIT_RESET   = 4'd5;

	// range codes
	localparam logic [1:0] RANGE_MIN   = 2'd0;
	localparam logic [1:0] RANGE_1X    = 2'd0;
	localparam logic [1:0] RANGE_2X    = 2'd1;
	localparam logic [1:0] RANGE_4X    = 2'd2;
	localparam logic [1:0] RANGE_MAX   = 2'd3;
	localparam logic [1:0] RANGE_RESET = 2'd2;

	localparam logic [3:0] COUNT_MAX = 4'd15;

	// floor(s * 122 / 100) as (s * 122 * ceil(2^26 / 100)) >> 26, exact for 12-bit s
	localparam int          VDD_SHIFT = 26;
	localparam logic [26:0] VDD_RECIP = 27'd81872858;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  channel;
		logic [11:0] sample;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  out_channel;
		logic [1:0]  scale;
		logic [12:0] millivolts;
	} out_item_t;

	// range table write from the decision stage
	typedef struct packed {
		logic       en;
		logic [5:0] chan;
		logic [1:0] rng;
	} rng_wr_t;

	// raw sample to millivolts at the given range
	function automatic logic [12:0] to_millivolts(input logic [11:0] s, input logic [1:0] rng);
		logic [38:0] prod;
		logic [12:0] mv;
		prod = 39'(s) * 39'(VDD_RECIP);
		case (rng)
			RANGE_1X: mv = 13'(s >> 2);
			RANGE_2X: mv = 13'(s >> 1);
			RANGE_4X: mv = 13'(s);
			default:  mv = prod[VDD_SHIFT +: 13];
		endcase
		return mv;
	endfunction

endpackage

FILE: design/aars_range_mem.sv
module aars_range_mem #(
	parameter int DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [5:0]      rd_chan,
	output logic [1:0]      rd_rng,
	input  aars_pkg::rng_wr_t wr
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [1:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [1:0]       rdata_q;
	logic             rvld_q;

	// entry valid bits, an unwritten entry reads as the reset range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[AW'(wr.chan)] <= 1'b1;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[AW'(wr.chan)] <= wr.rng;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[AW'(rd_chan)];
			rvld_q  <= vld_q[AW'(rd_chan)];
		end
	end

	assign rd_rng = rvld_q ? rdata_q : aars_pkg::RANGE_RESET;

endmodule

FILE: design/aars_step.sv
module aars_step #(
	parameter int CHANNELS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  aars_pkg::in_item_t item,
	input  logic [1:0]         mem_rng,
	input  logic [11:0]        low_threshold,
	input  logic [11:0]        high_threshold,
	input  logic [3:0]         settle_limit,
	output logic               res_vld,
	output aars_pkg::out_item_t res,
	output aars_pkg::rng_wr_t  wr
);

	localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

	logic       busy_q, busy_d;
	logic [5:0] active_q, active_d;
	logic [3:0] count_q, count_d;
	logic       fp_q, fp_d;
	logic [1:0] rng_q, rng_d;

	logic [1:0] start_rng;
	logic       lo_hit, hi_hit;

	// the cached range always mirrors the table entry of the active channel
	assign start_rng = (item.channel == active_q) ? rng_q : mem_rng;
	assign lo_hit    = item.sample < low_threshold;
	assign hi_hit    = item.sample > high_threshold;

	// decision for one item
	always_comb begin
		busy_d   = busy_q;
		active_d = active_q;
		count_d  = count_q;
		fp_d     = fp_q;
		rng_d    = rng_q;
		res_vld  = 1'b0;
		res      = '0;
		wr       = '0;
		if (fire) begin
			if (item.cmd == aars_pkg::CMD_START) begin
				if ({3'b000, item.channel} < CH_LIMIT) begin
					busy_d          = 1'b1;
					active_d        = item.channel;
					count_d         = '0;
					fp_d            = 1'b0;
					rng_d           = start_rng;
					res_vld         = 1'b1;
					res.kind        = aars_pkg::KIND_REQUEST;
					res.out_channel = item.channel;
					res.scale       = start_rng;
				end
			end else if (busy_q) begin
				res_vld         = 1'b1;
				res.out_channel = active_q;
				res.kind        = aars_pkg::KIND_READING;
				res.scale       = rng_q;
				res.millivolts  = aars_pkg::to_millivolts(item.sample, rng_q);
				busy_d          = 1'b0;
				if (fp_q) begin
					fp_d = 1'b0;
				end else if (count_q >= settle_limit) begin
					// final pass: one step up allowed, then a last conversion
					if (hi_hit && rng_q != aars_pkg::RANGE_MAX) begin
						rng_d = rng_q + 2'd1;
						fp_d  = 1'b1;
					end
				end else begin
					if (count_q != aars_pkg::COUNT_MAX) begin
						count_d = count_q + 4'd1;
					end
					if (lo_hit) begin
						if (rng_q != aars_pkg::RANGE_MIN) begin
							rng_d = rng_q - 2'd1;
						end
					end else if (hi_hit) begin
						if (rng_q != aars_pkg::RANGE_MAX) begin
							rng_d = rng_q + 2'd1;
						end
					end
				end
				// a range step turns the reading into a new request
				if (rng_d != rng_q) begin
					busy_d         = 1'b1;
					res.kind       = aars_pkg::KIND_REQUEST;
					res.scale      = rng_d;
					res.millivolts = '0;
					wr.en          = 1'b1;
					wr.chan        = active_q;
					wr.rng         = rng_d;
				end
			end
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			active_q <= '0;
			count_q  <= '0;
			fp_q     <= 1'b0;
			rng_q    <= aars_pkg::RANGE_RESET;
		end else begin
			busy_q   <= busy_d;
			active_q <= active_d;
			count_q  <= count_d;
			fp_q     <= fp_d;
			rng_q    <= rng_d;
		end
	end

endmodule

FILE: design/adc_auto_range_sequencer_unit.sv
// Auto-ranging ADC sequencer.
// Input channel (in_valid/in_ready/in_data): a start command names an analog
// channel, a sample command returns a 12-bit conversion result for the
// channel being read. Output channel (out_valid/out_ready/out_data) carries
// either a conversion request at a given range or the final millivolt reading.
// Each channel keeps its range in a table that stays between reads.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (low threshold, high threshold, settle limit); write only while idle.
// A result passes the input register, where the range table is read, then the
// decision into the output register, which drives out_valid.
// Throughput: one item per cycle unless stalled; the range table read and the
// decision share one stage, and the cached active range covers back-to-back
// items. A stalled receiver holds the output register; the input stage then
// holds one further item and in_ready drops until the output is taken.
// Reset clears the table to the 4096 mV range through per-entry valid bits,
// with no clearing pass, and restores the register reset values.
module adc_auto_range_sequencer_unit #(
	parameter int CHANNELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  aars_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output aars_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [11:0]         cfg_data
);

	logic [11:0]         low_q, high_q;
	logic [3:0]          limit_q;
	logic                vld_s1;
	aars_pkg::in_item_t  item_s1;
	logic                adv_s1, in_xfer;
	logic [1:0]          mem_rng;
	logic                res_vld;
	aars_pkg::out_item_t res;
	aars_pkg::rng_wr_t   wr;
	logic                out_vld_q;
	aars_pkg::out_item_t out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= aars_pkg::LOW_THRESHOLD_RESET;
			high_q  <= aars_pkg::HIGH_THRESHOLD_RESET;
			limit_q <= aars_pkg::SETTLE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				aars_pkg::REG_LOW_THRESHOLD:  low_q   <= cfg_data;
				aars_pkg::REG_HIGH_THRESHOLD: high_q  <= cfg_data;
				aars_pkg::REG_SETTLE_LIMIT:   limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// handshake between input stage and output register
	assign adv_s1   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv_s1;
	assign in_xfer  = in_valid && in_ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	// range table, read as the item enters the input stage
	aars_range_mem #(
		.DEPTH(CHANNELS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.rd_chan (in_data.channel),
		.rd_rng  (mem_rng),
		.wr      (wr)
	);

	// decision and sequencer state
	aars_step #(
		.CHANNELS(CHANNELS)
	) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (adv_s1),
		.item           (item_s1),
		.mem_rng        (mem_rng),
		.low_threshold  (low_q),
		.high_threshold (high_q),
		.settle_limit   (limit_q),
		.res_vld        (res_vld),
		.res            (res),
		.wr             (wr)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && res_vld) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_vld) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_req_no_mv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == aars_pkg::KIND_REQUEST |-> out_data.millivolts == 13'd0)
		else $error("conversion request carries a nonzero reading");

	a_mv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == aars_pkg::KIND_READING |-> out_data.millivolts <= 13'd4995)
		else $error("millivolt reading out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && out_vld_q && !out_ready |=> vld_s1 && $stable(item_s1))
		else $error("input stage item lost during output stall");

	a_wr_on_req: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> adv_s1 && res_vld && res.kind == aars_pkg::KIND_REQUEST)
		else $error("range table written without a new request");
`endif

endmodule
